// File: design/stnis_pkg.sv
// stnis_pkg: shared types and constants for the sorted table nearest index search
// holds table geometry, item op codes, result status codes and controller states
// no dependencies
`timescale 1ns / 1ps

package stnis_pkg;

    // table geometry
    localparam int DEPTH  = 4096;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int DATA_W = 32;

    // item op codes
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FOUND    = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WALK,
        ST_NOTFOUND,
        ST_RESULT
    } state_t;

endpackage

// File: design/sorted_table_nearest_index_search.sv
// sorted_table_nearest_index_search: ascending grid table with nearest index lookup
// one synchronous table memory, a walk controller and an output register
// depends on stnis_pkg
`timescale 1ns / 1ps

// The block holds up to 4096 ascending Q20.12 grid values in one memory with
// one write port and one registered read port, and uses at most one of them
// per cycle. A load, clear or unused item goes from ST_IDLE through ST_RESULT
// into the output register. A query whose start index is at or past the fill
// count goes through ST_NOTFOUND; one whose start entry is the last one and
// matches goes through ST_FETCH. Other found queries go through ST_FETCH and
// ST_WALK, which reads one entry per cycle from the remembered start index. A
// query that finds nothing ends in ST_NOTFOUND, which reads entry 0 for the
// snapped_value. ST_RESULT waits while the output register is full and out_ready
// is low. One item is worked on at a time; the next item is accepted the cycle
// after the result moves into the output register, even while that result still
// waits there. Ascending queries resume from the last bracket, so their walks
// stay short; set restart to walk from index 0. The table needs no clearing pass
// after reset: reads stay below the fill count, save an unused read of entry 0.
module sorted_table_nearest_index_search
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [stnis_pkg::DATA_W-1:0] value,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [stnis_pkg::IDX_W-1:0]  index,
    output logic [stnis_pkg::DATA_W-1:0] snapped_value
);

    localparam int IDX_W  = stnis_pkg::IDX_W;
    localparam int CNT_W  = stnis_pkg::CNT_W;
    localparam int DATA_W = stnis_pkg::DATA_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(stnis_pkg::DEPTH);

    // table memory
    logic [DATA_W-1:0] mem [stnis_pkg::DEPTH];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // control and working registers
    stnis_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [DATA_W-1:0]  lo_reg, lo_next;
    logic [DATA_W-1:0]  v_reg, v_next;

    // pending result
    stnis_pkg::status_t res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_index_reg, res_index_next;
    logic [DATA_W-1:0]  res_value_reg, res_value_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    stnis_pkg::status_t out_status_reg, out_status_next;
    logic [IDX_W-1:0]   out_index_reg, out_index_next;
    logic [DATA_W-1:0]  out_value_reg, out_value_next;

    logic               accept;
    logic               out_free;
    logic [IDX_W-1:0]   q_start;
    logic [CNT_W-1:0]   j_ext;
    logic [CNT_W-1:0]   j_plus1;
    logic [CNT_W-1:0]   j_plus2;
    logic [DATA_W-1:0]  diff_lo;
    logic [DATA_W-1:0]  diff_hi;

    assign in_ready      = (state_reg == stnis_pkg::ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign q_start       = restart ? '0 : start_reg;
    assign j_ext         = {1'b0, j_reg};
    assign j_plus1       = j_ext + CNT_W'(1);
    assign j_plus2       = j_ext + CNT_W'(2);
    assign diff_lo       = v_reg - lo_reg;
    assign diff_hi       = mem_rdata - v_reg;

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign index         = out_index_reg;
    assign snapped_value = out_value_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    // next state, memory access and results
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        j_next          = j_reg;
        lo_next         = lo_reg;
        v_next          = v_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = value;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        case (state_reg)
            stnis_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = stnis_pkg::STS_OK;
                    res_index_next  = '0;
                    res_value_next  = '0;
                    state_next      = stnis_pkg::ST_RESULT;
                    case (op)
                        stnis_pkg::OP_LOAD:
                        begin
                            if (count_reg < DEPTH_C)
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = stnis_pkg::STS_FULL;
                            end
                        end
                        stnis_pkg::OP_QUERY:
                        begin
                            v_next     = value;
                            start_next = q_start;
                            if ({1'b0, q_start} >= count_reg)
                            begin
                                mem_re     = 1'b1;
                                state_next = stnis_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = q_start;
                                j_next     = q_start;
                                state_next = stnis_pkg::ST_FETCH;
                            end
                        end
                        stnis_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            start_next = '0;
                        end
                        default:
                        begin
                            res_status_next = stnis_pkg::STS_OK;
                        end
                    endcase
                end
            end

            // first entry of the walk has arrived
            stnis_pkg::ST_FETCH:
            begin
                lo_next = mem_rdata;
                if (j_plus1 < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_plus1[IDX_W-1:0];
                    state_next = stnis_pkg::ST_WALK;
                end
                else if (mem_rdata == v_reg)
                begin
                    start_next      = j_reg;
                    res_status_next = stnis_pkg::STS_FOUND;
                    res_index_next  = j_reg;
                    res_value_next  = mem_rdata;
                    state_next      = stnis_pkg::ST_RESULT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = stnis_pkg::ST_NOTFOUND;
                end
            end

            // lo_reg holds entry j, read data holds entry j+1
            stnis_pkg::ST_WALK:
            begin
                if (lo_reg < v_reg && mem_rdata > v_reg)
                begin
                    start_next      = j_reg;
                    res_status_next = stnis_pkg::STS_FOUND;
                    if (diff_lo < diff_hi)
                    begin
                        res_index_next = j_reg;
                        res_value_next = lo_reg;
                    end
                    else
                    begin
                        res_index_next = j_plus1[IDX_W-1:0];
                        res_value_next = mem_rdata;
                    end
                    state_next = stnis_pkg::ST_RESULT;
                end
                else if (lo_reg == v_reg)
                begin
                    start_next      = j_reg;
                    res_status_next = stnis_pkg::STS_FOUND;
                    res_index_next  = j_reg;
                    res_value_next  = lo_reg;
                    state_next      = stnis_pkg::ST_RESULT;
                end
                else if (j_plus2 < count_reg)
                begin
                    // step one entry forward
                    j_next    = j_plus1[IDX_W-1:0];
                    lo_next   = mem_rdata;
                    mem_re    = 1'b1;
                    mem_raddr = j_plus2[IDX_W-1:0];
                end
                else if (mem_rdata == v_reg)
                begin
                    // last entry matches exactly
                    start_next      = j_plus1[IDX_W-1:0];
                    res_status_next = stnis_pkg::STS_FOUND;
                    res_index_next  = j_plus1[IDX_W-1:0];
                    res_value_next  = mem_rdata;
                    state_next      = stnis_pkg::ST_RESULT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = stnis_pkg::ST_NOTFOUND;
                end
            end

            // entry zero has arrived for the not found result
            stnis_pkg::ST_NOTFOUND:
            begin
                res_status_next = stnis_pkg::STS_NOTFOUND;
                res_index_next  = '0;
                res_value_next  = (count_reg != '0) ? mem_rdata : '0;
                state_next      = stnis_pkg::ST_RESULT;
            end

            // hand the result to the output register
            stnis_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_index_reg;
                    out_value_next  = res_value_reg;
                    state_next      = stnis_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stnis_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stnis_pkg::ST_IDLE;
            count_reg     <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        lo_reg         <= lo_next;
        v_reg          <= v_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
    end

endmodule
